[design/ska_pkg.sv]
`timescale 1ns / 1ps
package ska_pkg;

	localparam int unsigned AddrW = 3;

	localparam logic [7:0] NEG_SID     = 8'h7F;
	localparam logic [7:0] POS_SID     = 8'h67;
	localparam logic [7:0] SVC_ID      = 8'h27;
	localparam logic [7:0] NRC_SUBFUNC = 8'h12;
	localparam logic [7:0] NRC_LENGTH  = 8'h13;
	localparam logic [7:0] NRC_KEY     = 8'h35;
	localparam logic [7:0] NRC_DELAY   = 8'h37;
	localparam logic [7:0] SF_SEED     = 8'h01;
	localparam logic [7:0] SF_KEY      = 8'h02;

	localparam logic [7:0] LEN_SEED_REQ = 8'd2;
	localparam logic [7:0] LEN_KEY_REQ  = 8'd6;
	localparam logic [2:0] LEN_SEED_RSP = 3'd6;
	localparam logic [2:0] LEN_KEY_RSP  = 3'd2;
	localparam logic [2:0] LEN_NEG_RSP  = 3'd3;

	localparam logic [7:0] SEED_ADD1 = 8'h3A;
	localparam logic [7:0] SEED_ADD3 = 8'h7B;
	localparam logic [7:0] ZERO_FIX0 = 8'h24;
	localparam logic [7:0] ZERO_FIX3 = 8'h68;
	localparam logic [7:0] ONES_FIX0 = 8'hAA;
	localparam logic [7:0] ONES_FIX3 = 8'h55;

	localparam logic [31:0] SEED_RESET    = 32'h7856_3412;
	localparam logic [15:0] TIMEOUT_RESET = 16'd5000;
	localparam logic [15:0] PENALTY_RESET = 16'd10000;

	typedef enum logic {
		REG_UNLOCK_TIMEOUT = 1'b0,
		REG_PENALTY_DELAY  = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] unlock_timeout_ms;
		logic [15:0] penalty_delay_ms;
	} cfg_t;

	typedef struct packed {
		logic        cmd;
		logic [7:0]  req_len;
		logic [7:0]  sub_function;
		logic [31:0] key_bytes;
		logic [15:0] temp_adc;
	} item_t;

	typedef struct packed {
		logic [2:0]  resp_len;
		logic [7:0]  resp_byte0;
		logic [7:0]  resp_byte1;
		logic [7:0]  resp_byte2;
		logic [31:0] seed_out;
		logic        accepted;
		logic        unlocked;
	} res_t;

	function automatic logic [31:0] make_seed(input logic [31:0] t, input logic [15:0] adc);
		logic [7:0] b0, b1, b2, b3;
		b0 = t[7:0] ^ adc[7:0];
		b1 = t[15:8] + SEED_ADD1;
		b2 = t[23:16] ^ adc[11:4];
		b3 = t[31:24] + SEED_ADD3;
		if ({b3, b2, b1, b0} == 32'h0000_0000) begin
			b0 = ZERO_FIX0;
			b3 = ZERO_FIX3;
		end else if ({b3, b2, b1, b0} == 32'hFFFF_FFFF) begin
			b0 = ONES_FIX0;
			b3 = ONES_FIX3;
		end
		return {b3, b2, b1, b0};
	endfunction

	function automatic logic [31:0] expected_key(input logic [31:0] s);
		logic [7:0] k0, k1, k2, k3;
		k0 = s[7:0] ^ s[15:8];
		k1 = s[15:8] + s[23:16];
		k2 = s[23:16] ^ s[31:24];
		k3 = s[31:24] + s[7:0];
		return {k3, k2, k1, k0};
	endfunction

endpackage

[design/ska_cfg_regs.sv]
`timescale 1ns / 1ps
module ska_cfg_regs import ska_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output cfg_t             cfg
);

	cfg_t     cfg_q;
	logic     wr_en;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	// decode by word: the low byte-offset bits are ignored
	assign idx    = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.unlock_timeout_ms <= TIMEOUT_RESET;
			cfg_q.penalty_delay_ms  <= PENALTY_RESET;
		end else if (wr_en) begin
			case (idx)
				REG_UNLOCK_TIMEOUT: cfg_q.unlock_timeout_ms <= pwdata[15:0];
				REG_PENALTY_DELAY:  cfg_q.penalty_delay_ms  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_UNLOCK_TIMEOUT: prdata = {16'h0000, cfg_q.unlock_timeout_ms};
			REG_PENALTY_DELAY:  prdata = {16'h0000, cfg_q.penalty_delay_ms};
			default:            prdata = 32'h0000_0000;
		endcase
	end

	assign cfg = cfg_q;

endmodule

[design/ska_core.sv]
`timescale 1ns / 1ps
module ska_core import ska_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  adv,
	input  item_t item,
	input  cfg_t  cfg,
	output res_t  res
);

	logic [31:0] ms_counter_q;
	logic        unlocked_q;
	logic [15:0] unlock_left_q;
	logic [15:0] penalty_left_q;
	logic [31:0] seed_q;
	logic        seed_valid_q;

	logic [31:0] ms_counter_d;
	logic        unlocked_d;
	logic [15:0] unlock_left_d;
	logic [15:0] penalty_left_d;
	logic [31:0] seed_d;
	logic        seed_valid_d;

	logic [31:0] new_seed;
	logic        key_ok;
	logic [15:0] unlock_dec;
	logic [7:0]  nrc;

	assign new_seed   = make_seed(ms_counter_q, item.temp_adc);
	assign key_ok     = (item.key_bytes == expected_key(seed_q));
	assign unlock_dec = (unlock_left_q != 16'd0) ? unlock_left_q - 16'd1 : 16'd0;

	always_comb begin
		ms_counter_d   = ms_counter_q;
		unlocked_d     = unlocked_q;
		unlock_left_d  = unlock_left_q;
		penalty_left_d = penalty_left_q;
		seed_d         = seed_q;
		seed_valid_d   = seed_valid_q;
		nrc            = 8'h00;
		res            = '0;

		if (!item.cmd) begin
			ms_counter_d = ms_counter_q + 32'd1;
			if (unlocked_q) begin
				unlock_left_d = unlock_dec;
				if (unlock_dec == 16'd0) begin
					unlocked_d   = 1'b0;
					seed_valid_d = 1'b0;
				end
			end
			if (penalty_left_q != 16'd0) penalty_left_d = penalty_left_q - 16'd1;
		end else if (item.req_len < LEN_SEED_REQ) begin
			nrc = NRC_LENGTH;
		end else if (item.sub_function == SF_SEED) begin
			if (item.req_len != LEN_SEED_REQ) begin
				nrc = NRC_LENGTH;
			end else if (penalty_left_q != 16'd0) begin
				nrc = NRC_DELAY;
			end else begin
				seed_d         = new_seed;
				seed_valid_d   = 1'b1;
				res.resp_len   = LEN_SEED_RSP;
				res.resp_byte0 = POS_SID;
				res.resp_byte1 = SF_SEED;
				res.seed_out   = new_seed;
				res.accepted   = 1'b1;
			end
		end else if (item.sub_function == SF_KEY) begin
			if (item.req_len != LEN_KEY_REQ) begin
				nrc = NRC_LENGTH;
			end else if (!seed_valid_q) begin
				nrc = NRC_KEY;
			end else if (key_ok) begin
				unlocked_d     = 1'b1;
				unlock_left_d  = cfg.unlock_timeout_ms;
				seed_valid_d   = 1'b0;
				res.resp_len   = LEN_KEY_RSP;
				res.resp_byte0 = POS_SID;
				res.resp_byte1 = SF_KEY;
				res.accepted   = 1'b1;
			end else begin
				unlocked_d     = 1'b0;
				unlock_left_d  = 16'd0;
				seed_valid_d   = 1'b0;
				penalty_left_d = cfg.penalty_delay_ms;
				nrc            = NRC_KEY;
			end
		end else begin
			nrc = NRC_SUBFUNC;
		end

		if (nrc != 8'h00) begin
			res.resp_len   = LEN_NEG_RSP;
			res.resp_byte0 = NEG_SID;
			res.resp_byte1 = SVC_ID;
			res.resp_byte2 = nrc;
		end
		res.unlocked = unlocked_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_counter_q   <= 32'd0;
			unlocked_q     <= 1'b0;
			unlock_left_q  <= 16'd0;
			penalty_left_q <= 16'd0;
			seed_q         <= SEED_RESET;
			seed_valid_q   <= 1'b0;
		end else if (adv) begin
			ms_counter_q   <= ms_counter_d;
			unlocked_q     <= unlocked_d;
			unlock_left_q  <= unlock_left_d;
			penalty_left_q <= penalty_left_d;
			seed_q         <= seed_d;
			seed_valid_q   <= seed_valid_d;
		end
	end

	// a locked block never has unlock time left
	a_locked_no_time: assert property (@(posedge clk) disable iff (!arst_n)
		!unlocked_q |-> unlock_left_q == 16'd0)
		else $error("unlock countdown running while locked");

	// a state change only happens when a word moves on
	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(ms_counter_q) && $stable(seed_valid_q) && $stable(unlocked_q))
		else $error("core state changed without an item");

endmodule

[design/seed_key_security_access_top.sv]
`timescale 1ns / 1ps
// Security-access responder for diagnostic service 0x27. Each input word is a
// one-millisecond tick (cmd = 0) or a request (cmd = 1) and yields exactly one
// result word; ticks give a zero-length result that still reports the unlocked
// flag for the LED. One word is taken every cycle unless in_stall is high: a
// word is held in the input register, the seed/key logic runs between it and
// the result register, and out_valid rises once the result register has loaded.
// in_stall rises only when the input register is full and the result register
// is held by out_stall. The unlock timeout and penalty delay registers (byte
// addresses 0x0 and 0x4) should only be written while no word is in flight.
module seed_key_security_access_top import ska_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             cmd,
	input  logic [7:0]       req_len,
	input  logic [7:0]       sub_function,
	input  logic [31:0]      key_bytes,
	input  logic [15:0]      temp_adc,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [2:0]       resp_len,
	output logic [7:0]       resp_byte0,
	output logic [7:0]       resp_byte1,
	output logic [7:0]       resp_byte2,
	output logic [31:0]      seed_out,
	output logic             accepted,
	output logic             unlocked
);

	cfg_t  cfg;
	item_t item_s1;
	logic  valid_s1;
	res_t  res_c;
	res_t  res_s2;
	logic  valid_s2;
	logic  adv;
	logic  in_fire;

	ska_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// advance when the result register is empty or being drained
	assign adv      = valid_s1 & (~valid_s2 | ~out_stall);
	assign in_stall = valid_s1 & ~adv;
	assign in_fire  = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1 <= '{cmd: cmd, req_len: req_len, sub_function: sub_function,
				key_bytes: key_bytes, temp_adc: temp_adc};
		end
	end

	ska_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) res_s2 <= res_c;
	end

	assign out_valid  = valid_s2;
	assign resp_len   = res_s2.resp_len;
	assign resp_byte0 = res_s2.resp_byte0;
	assign resp_byte1 = res_s2.resp_byte1;
	assign resp_byte2 = res_s2.resp_byte2;
	assign seed_out   = res_s2.seed_out;
	assign accepted   = res_s2.accepted;
	assign unlocked   = res_s2.unlocked;

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_stall)
		else $error("input stalled with room to advance");

	a_seed_not_degenerate: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted && resp_len == LEN_SEED_RSP |->
		seed_out != 32'h0000_0000 && seed_out != 32'hFFFF_FFFF)
		else $error("degenerate seed sent");

	a_positive_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted |-> resp_byte0 == POS_SID && resp_byte2 == 8'h00)
		else $error("positive response with wrong id or code");

endmodule
